FILE: rtl/core/dda_line_rasterizer_core_defines.svh
// assertion macros shared by the dda line rasterizer core
// expects signals named clk and rst_n in the module that uses them
`ifndef DDA_LINE_RASTERIZER_CORE_DEFINES_SVH
`define DDA_LINE_RASTERIZER_CORE_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define DDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dda_pkg.sv
// shared types and constants for the dda line rasterizer core
// no dependencies
`default_nettype none

package dda_pkg;

  // fixed field widths of the stream words
  localparam int FIELD_W    = 15;
  localparam int COLOR_W    = 24;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;

  // default parameter values
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 15;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFFFFF;

  // command codes carried in tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic div_iter;
    logic div_sign;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic load_zero;
  } ctrl_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/dda_datapath.sv
// datapath of the dda line rasterizer: endpoint decode, shared-step
// divider for both axes, position accumulators and output word register
// depends on dda_pkg
`default_nettype none

module dda_datapath #(
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dda_pkg::ctrl_cmd_t             cmd,
  output dda_pkg::ctrl_stat_t            stat,
  input  logic                           cfg_wr_en,
  input  logic [dda_pkg::COLOR_W-1:0]    cfg_wr_data,
  input  logic [dda_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic [dda_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  output logic                           out_tuser
);

  localparam int FIELD_W = dda_pkg::FIELD_W;
  localparam int COLOR_W = dda_pkg::COLOR_W;
  localparam int ODW     = dda_pkg::OUT_DATA_W;
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int MAG_W   = COORD_BITS;
  localparam int REM_W   = COORD_BITS + 1;
  localparam int QUO_W   = FRAC_BITS + 1;
  localparam int INC_W   = FRAC_BITS + 2;
  localparam int POS_W   = COORD_BITS + FRAC_BITS + 1;
  localparam logic [POS_W-1:0] TRUNC_BIAS = POS_W'((64'd1 << FRAC_BITS) - 64'd1);

  // endpoint decode
  logic [FIELD_W-1:0] f_sx, f_sy, f_ex, f_ey;
  logic signed [COORD_BITS-1:0] c_sx, c_sy, c_ex, c_ey;
  logic signed [DIFF_W-1:0] sx, sy, ex, ey, dx, dy;
  logic [MAG_W-1:0] ax, ay, steps;

  assign f_sx = in_tdata[0*FIELD_W +: FIELD_W];
  assign f_sy = in_tdata[1*FIELD_W +: FIELD_W];
  assign f_ex = in_tdata[2*FIELD_W +: FIELD_W];
  assign f_ey = in_tdata[3*FIELD_W +: FIELD_W];
  assign c_sx = f_sx[COORD_BITS-1:0];
  assign c_sy = f_sy[COORD_BITS-1:0];
  assign c_ex = f_ex[COORD_BITS-1:0];
  assign c_ey = f_ey[COORD_BITS-1:0];
  assign sx = DIFF_W'(c_sx);
  assign sy = DIFF_W'(c_sy);
  assign ex = DIFF_W'(c_ex);
  assign ey = DIFF_W'(c_ey);
  assign dx = ex - sx;
  assign dy = ey - sy;
  assign ax = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
  assign ay = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
  // tie goes to y, same magnitude either way
  assign steps = (ax > ay) ? ax : ay;
  assign stat.load_zero = (steps == '0);

  // line state
  logic signed [POS_W-1:0] pos_x_r, pos_y_r;
  logic signed [INC_W-1:0] inc_x_r, inc_y_r;
  logic [MAG_W-1:0] steps_left_r, div_r;
  logic [REM_W-1:0] rem_x_r, rem_y_r;
  logic [QUO_W-1:0] quo_x_r, quo_y_r;
  logic neg_x_r, neg_y_r;
  logic [COLOR_W-1:0] color_r;
  logic [ODW-1:0] out_data_r, out_data_nxt;
  logic out_last_r, out_last_nxt, out_user_r, out_user_nxt;

  // one restoring division step per axis
  logic ge_x, ge_y;
  logic [REM_W-1:0] rsel_x, rsel_y, rem_x_nxt, rem_y_nxt;
  logic [QUO_W-1:0] quo_x_nxt, quo_y_nxt;

  assign ge_x = rem_x_r >= REM_W'(div_r);
  assign ge_y = rem_y_r >= REM_W'(div_r);
  assign rsel_x = ge_x ? rem_x_r - REM_W'(div_r) : rem_x_r;
  assign rsel_y = ge_y ? rem_y_r - REM_W'(div_r) : rem_y_r;
  assign rem_x_nxt = {rsel_x[REM_W-2:0], 1'b0};
  assign rem_y_nxt = {rsel_y[REM_W-2:0], 1'b0};
  assign quo_x_nxt = {quo_x_r[QUO_W-2:0], ge_x};
  assign quo_y_nxt = {quo_y_r[QUO_W-2:0], ge_y};

  // position truncated toward zero
  logic [POS_W-1:0] sum_x, sum_y;
  logic signed [COORD_BITS:0] tx, ty;
  logic [FIELD_W-1:0] pix_x, pix_y;

  assign sum_x = pos_x_r + (pos_x_r[POS_W-1] ? TRUNC_BIAS : '0);
  assign sum_y = pos_y_r + (pos_y_r[POS_W-1] ? TRUNC_BIAS : '0);
  assign tx = sum_x[POS_W-1:FRAC_BITS];
  assign ty = sum_y[POS_W-1:FRAC_BITS];
  assign pix_x = FIELD_W'(tx);
  assign pix_y = FIELD_W'(ty);

  // next output word
  always_comb begin
    out_data_nxt = '0;
    out_last_nxt = 1'b1;
    out_user_nxt = 1'b0;
    if (cmd.load) begin
      out_last_nxt = stat.load_zero;
    end else if (steps_left_r != '0) begin
      out_data_nxt = ODW'({color_r, pix_y, pix_x});
      out_last_nxt = (steps_left_r == MAG_W'(1));
      out_user_nxt = 1'b1;
    end
  end

  // control-like state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_left_r <= '0;
      color_r      <= dda_pkg::COLOR_RESET;
    end else begin
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        steps_left_r <= steps;
      end else if (cmd.step && steps_left_r != '0) begin
        steps_left_r <= steps_left_r - MAG_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.step) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
      out_user_r <= out_user_nxt;
    end
    if (cmd.load) begin
      pos_x_r <= POS_W'(sx) <<< FRAC_BITS;
      pos_y_r <= POS_W'(sy) <<< FRAC_BITS;
      div_r   <= steps;
      rem_x_r <= REM_W'(ax);
      rem_y_r <= REM_W'(ay);
      quo_x_r <= '0;
      quo_y_r <= '0;
      neg_x_r <= dx[DIFF_W-1];
      neg_y_r <= dy[DIFF_W-1];
      inc_x_r <= '0;
      inc_y_r <= '0;
    end else if (cmd.step && steps_left_r != '0) begin
      pos_x_r <= pos_x_r + POS_W'(inc_x_r);
      pos_y_r <= pos_y_r + POS_W'(inc_y_r);
    end
    if (cmd.div_iter) begin
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      quo_x_r <= quo_x_nxt;
      quo_y_r <= quo_y_nxt;
    end
    if (cmd.div_sign) begin
      inc_x_r <= neg_x_r ? -INC_W'(quo_x_r) : INC_W'(quo_x_r);
      inc_y_r <= neg_y_r ? -INC_W'(quo_y_r) : INC_W'(quo_y_r);
    end
  end

  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;
  assign out_tuser = out_user_r;

endmodule

`default_nettype wire

FILE: rtl/core/dda_ctrl.sv
// controller of the dda line rasterizer: handshake, divider sequencing
// and output word valid flag
// depends on dda_pkg and dda_line_rasterizer_core_defines.svh
`default_nettype none
`include "dda_line_rasterizer_core_defines.svh"

module dda_ctrl #(
  parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tuser,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  dda_pkg::ctrl_stat_t stat,
  output dda_pkg::ctrl_cmd_t  cmd
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  dda_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  // accept only when idle and the output word can be replaced
  assign in_tready = (state_r == dda_pkg::ST_IDLE) && (!out_valid_r || out_tready);
  assign accept = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.load     = accept && (in_tuser == dda_pkg::CMD_LOAD);
    cmd.step     = accept && (in_tuser == dda_pkg::CMD_NEXT);
    cmd.div_iter = 1'b0;
    cmd.div_sign = 1'b0;
    unique case (state_r)
      dda_pkg::ST_IDLE: begin
        if (cmd.load && !stat.load_zero) begin
          state_nxt = dda_pkg::ST_DIV;
          cnt_nxt   = CNT_W'(FRAC_BITS);
        end
      end
      dda_pkg::ST_DIV: begin
        cmd.div_iter = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = dda_pkg::ST_SIGN;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      dda_pkg::ST_SIGN: begin
        cmd.div_sign = 1'b1;
        state_nxt    = dda_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = dda_pkg::ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dda_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  `DDA_ASSERT(a_no_accept_in_div, (state_r == dda_pkg::ST_DIV) |-> !in_tready, "ready during divide")
  `DDA_ASSERT_NEXT(a_load_starts_div, cmd.load && !stat.load_zero, state_r == dda_pkg::ST_DIV, "divide not started")
  `DDA_ASSERT_NEXT(a_sign_to_idle, state_r == dda_pkg::ST_SIGN, state_r == dda_pkg::ST_IDLE, "sign step not final")
  `DDA_ASSERT_NEXT(a_accept_gives_word, in_tvalid && in_tready, out_tvalid, "accepted word lost")

endmodule

`default_nettype wire

FILE: rtl/core/dda_line_rasterizer_core.sv
// DDA line rasterizer core
// Input stream: in_tuser is the command (0 load endpoints, 1 next pixel),
// in_tdata carries start_x, start_y, end_x, end_y. Every accepted word
// gives exactly one output word: out_tuser marks a pixel, out_tlast says
// no pixel of the current line remains, out_tdata carries x, y and color.
// The result of a word is registered and shows in the cycle after
// acceptance, and a new word is taken each cycle while the receiver keeps
// up. A load with nonzero length runs the per-axis divider, one quotient
// bit per cycle for both axes, and no word is taken until the divider and
// its sign step are done; a zero-length load skips the divider.
// cfg_wr_en writes the draw color at any idle time.
// Synchronous reset (rst_n low) clears the line, empties the output
// register and sets the color to white. When out_tready is low the output
// word holds and in_tready drops until the word is taken.
// depends on dda_pkg, dda_ctrl, dda_datapath
`default_nettype none

module dda_line_rasterizer_core #(
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [dda_pkg::COLOR_W-1:0]    cfg_wr_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // start_x[14:0], start_y[29:15], end_x[44:30], end_y[59:45], zero pad
  input  logic [dda_pkg::IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_x[14:0], pixel_y[29:15], pixel_color[53:30], zero pad
  output logic [dda_pkg::OUT_DATA_W-1:0] out_tdata,
  // line_done
  output logic                           out_tlast,
  // pixel_valid
  output logic                           out_tuser
);

  dda_pkg::ctrl_cmd_t  cmd;
  dda_pkg::ctrl_stat_t stat;

  // sequencing and handshake
  dda_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // arithmetic and line state
  dda_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire

FILE: verif/dda_line_rasterizer_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for dda_line_rasterizer_core: stream words in, pixels checked out
// holds its own line-stepping predictor in a small scoreboard class; depends on dda_pkg

module dda_line_rasterizer_core_tb;
  import dda_pkg::*;

  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  // one expected output word
  typedef struct {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               done;
    logic               pix;
  } pixel_word_t;

  // tracks the line being stepped and the pixels still owed by the block
  class pixel_scoreboard;
    longint             pos_x, pos_y;
    longint             inc_x, inc_y;
    int unsigned        steps_left;
    logic [COLOR_W-1:0] color;
    pixel_word_t        pending[$];
    int                 mismatches;

    function new();
      pos_x = 0;
      pos_y = 0;
      inc_x = 0;
      inc_y = 0;
      steps_left = 0;
      color = COLOR_RESET;
      mismatches = 0;
    endfunction

    // per-axis slope, fraction truncated toward zero
    function longint axis_increment(longint d, longint steps);
      longint q;
      q = ((d < 0 ? -d : d) << FRAC) / steps;
      return d < 0 ? -q : q;
    endfunction

    // integer part of a fixed-point position, toward zero
    function longint whole_part(longint p);
      return p < 0 ? -((-p) >>> FRAC) : (p >>> FRAC);
    endfunction

    function void note_word(logic cmd, logic [IN_DATA_W-1:0] data);
      pixel_word_t e;
      longint      sx, sy, dx, dy, ax, ay, steps, wx, wy;
      e.x = '0;
      e.y = '0;
      e.color = '0;
      e.pix = 1'b0;
      e.done = 1'b0;
      if (cmd == CMD_LOAD) begin
        sx = longint'($signed(data[14:0]));
        sy = longint'($signed(data[29:15]));
        dx = longint'($signed(data[44:30])) - sx;
        dy = longint'($signed(data[59:45])) - sy;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        steps = ax > ay ? ax : ay;
        steps_left = steps;
        pos_x = sx * (longint'(1) << FRAC);
        pos_y = sy * (longint'(1) << FRAC);
        if (steps != 0) begin
          inc_x = axis_increment(dx, steps);
          inc_y = axis_increment(dy, steps);
        end else begin
          inc_x = 0;
          inc_y = 0;
        end
        e.done = (steps == 0);
      end else if (steps_left == 0) begin
        // line exhausted: empty word, state untouched
        e.done = 1'b1;
      end else begin
        wx = whole_part(pos_x);
        wy = whole_part(pos_y);
        e.x = wx[FIELD_W-1:0];
        e.y = wy[FIELD_W-1:0];
        e.pix = 1'b1;
        e.color = color;
        pos_x += inc_x;
        pos_y += inc_y;
        steps_left -= 1;
        e.done = (steps_left == 0);
      end
      pending.push_back(e);
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] data, logic last, logic user);
      pixel_word_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected output word data=%h last=%b user=%b",
                   $realtime, data, last, user);
        return;
      end
      e = pending.pop_front();
      if (data[14:0] !== e.x || data[29:15] !== e.y || data[53:30] !== e.color ||
          last !== e.done || user !== e.pix) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp x=%h y=%h color=%h done=%b pix=%b",
                   $realtime, e.x, e.y, e.color, e.done, e.pix);
          $display("%0t:          got x=%h y=%h color=%h done=%b pix=%b",
                   $realtime, data[14:0], data[29:15], data[53:30], last, user);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [COLOR_W-1:0]    cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // start_x, start_y, end_x, end_y, zero pad
  logic                  in_tuser;   // command
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // pixel_x, pixel_y, pixel_color, zero pad
  logic                  out_tlast;  // line_done
  logic                  out_tuser;  // pixel_valid

  pixel_scoreboard sb;
  bit              tx_idle;
  bit              rx_idle;
  bit              hold_req = 1'b0;
  bit              hold_done = 1'b0;
  int              stall_cycles = 0;

  dda_line_rasterizer_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  always #2 clk = ~clk;

  // check every word taken from the block
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(out_tdata, out_tlast, out_tuser);
  end

  // watchdog on cycles where neither side moves a word
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (rx_idle) begin
        out_tready <= ($urandom_range(99) >= 26);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_line(int sx, int sy, int ex, int ey);
    return {4'b0, ey[14:0], ex[14:0], sy[14:0], sx[14:0]};
  endfunction

  // coordinate biased toward the edges of the range
  function automatic int pick_coord();
    case ($urandom_range(3))
      0:       return -16384 + int'($urandom_range(24));
      1:       return 16383 - int'($urandom_range(24));
      default: return int'($urandom_range(32767)) - 16384;
    endcase
  endfunction

  // offer one word, with optional random gaps before it
  task automatic send_word(input logic cmd, input logic [IN_DATA_W-1:0] data);
    if (tx_idle) begin
      while ($urandom_range(99) < 26) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    sb.note_word(cmd, data);
  endtask

  task automatic send_load(input int sx, input int sy, input int ex, input int ey);
    send_word(CMD_LOAD, pack_line(sx, sy, ex, ey));
  endtask

  task automatic send_next(input int count);
    repeat (count) send_word(CMD_NEXT, {$urandom, $urandom});
  endtask

  // write the draw color once the block has drained
  task automatic write_color(input logic [COLOR_W-1:0] c);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.color = c;
  endtask

  // mostly whole short lines, some wild endpoints, some noise
  task automatic run_lines(input int n);
    int sent, kind, sx, sy, ex, ey, dx, dy, steps, nexts;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      if (kind < 85) begin
        if (kind < 70) begin
          sx = pick_coord();
          sy = pick_coord();
          dx = int'($urandom_range(48)) - 24;
          dy = int'($urandom_range(48)) - 24;
          ex = sx + dx;
          if (ex > 16383 || ex < -16384) ex = sx - dx;
          ey = sy + dy;
          if (ey > 16383 || ey < -16384) ey = sy - dy;
        end else begin
          sx = int'($urandom_range(32767)) - 16384;
          sy = int'($urandom_range(32767)) - 16384;
          ex = int'($urandom_range(32767)) - 16384;
          ey = int'($urandom_range(32767)) - 16384;
        end
        send_load(sx, sy, ex, ey);
        dx = ex > sx ? ex - sx : sx - ex;
        dy = ey > sy ? ey - sy : sy - ey;
        steps = dx > dy ? dx : dy;
        if (kind >= 70)
          nexts = $urandom_range(4);
        else if ($urandom_range(9) == 0)
          nexts = $urandom_range(steps);  // cut the line short
        else
          nexts = steps + int'($urandom_range(2));
        send_next(nexts);
        sent += 1 + nexts;
      end else if (kind < 93) begin
        send_next(1);
        sent++;
      end else begin
        sx = pick_coord();
        sy = pick_coord();
        send_load(sx, sy, sx, sy);
        sent++;
      end
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tuser    <= CMD_LOAD;
    in_tdata    <= '0;
    tx_idle  = 1'b1;
    rx_idle  = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // next with no line loaded
    send_next(1);
    // zero-length line, then next past it
    send_load(5, 5, 5, 5);
    send_next(1);
    // full-range diagonals, tie goes to y
    send_load(-16384, -16384, 16383, 16383);
    send_next(3);
    send_load(16383, -16384, -16384, 16383);
    send_next(2);
    // steep line, negative x: truncation toward zero
    send_load(0, 0, -3, 7);
    send_next(8);
    // shallow line, dropped part way by a new load
    send_load(-5, -2, 4, -6);
    send_next(3);
    send_load(-1, -1, 1, -1);
    send_next(3);

    write_color('0);
    run_lines(185);

    // stretch with no idling on either side
    write_color(24'hFFFFFF);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_lines(185);

    // receiver holds off while the sender keeps offering
    write_color(COLOR_W'($urandom));
    rx_idle  = 1'b1;
    hold_req = 1'b1;
    run_lines(185);

    write_color(COLOR_W'($urandom));
    tx_idle = 1'b1;
    run_lines(185);

    write_color(COLOR_W'($urandom));
    run_lines(185);

    // drain
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
